### hw/rtl/ofw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ofw_pkg;

    // Ring depth and the widths that follow from it.
    localparam int FRAME_MAX = 64;
    localparam int RING_AW   = $clog2(FRAME_MAX);
    localparam int LEN_W     = $clog2(FRAME_MAX + 1);

    // Fixed field widths.
    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int WIN_AW      = 6;
    localparam int WIN_DEPTH   = 1 << WIN_AW;
    localparam int POS_W       = 6;
    localparam int FRAME_NUM_W = 16;
    localparam int REG_W       = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;

    // Windowing arithmetic: Q1.15 coefficient, round half up.
    localparam int PROD_W     = SAMPLE_W + COEF_W + 2;
    localparam int FRAC_BITS  = 15;
    localparam int ROUND_BIAS = 1 << (FRAC_BITS - 1);

    // Configuration register indices.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOP       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_ON = 2'd2;

    // Input item kinds.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    // Frame length as actually used: zero acts as one, oversize is clamped.
    function automatic logic [LEN_W-1:0] eff_len(input logic [REG_W-1:0] frame_len);
        logic [LEN_W-1:0] len;
        if (frame_len == '0) begin
            len = LEN_W'(1);
        end else if (frame_len > REG_W'(FRAME_MAX)) begin
            len = LEN_W'(FRAME_MAX);
        end else begin
            len = LEN_W'(frame_len);
        end
        return len;
    endfunction

    // Hop as actually used: zero means one frame length.
    function automatic logic [REG_W-1:0] eff_hop(input logic [REG_W-1:0] hop,
                                                input logic [REG_W-1:0] frame_len);
        logic [REG_W-1:0] h;
        if (hop == '0) begin
            h = REG_W'(eff_len(frame_len));
        end else begin
            h = hop;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/ofw_mac.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared windowing unit: one registered multiply, then rounding and saturation.
module ofw_mac (
    input  wire logic                                aclk,
    input  wire logic                                en,
    input  wire logic                                window_on,
    input  wire logic signed [ofw_pkg::SAMPLE_W-1:0] raw,
    input  wire logic [ofw_pkg::COEF_W-1:0]          coef,
    output logic signed [ofw_pkg::SAMPLE_W-1:0]      value
);

    localparam int HI_W = ofw_pkg::PROD_W - ofw_pkg::FRAC_BITS;

    logic signed [ofw_pkg::COEF_W:0]     coef_s;
    logic signed [ofw_pkg::PROD_W-1:0]   raw_ext;
    logic signed [ofw_pkg::PROD_W-1:0]   coef_ext;
    logic signed [ofw_pkg::PROD_W-1:0]   prod_reg;
    logic signed [ofw_pkg::SAMPLE_W-1:0] raw_reg;
    logic signed [ofw_pkg::PROD_W-1:0]   rounded;
    logic signed [HI_W-1:0]              quot;
    logic                                overflow;
    logic signed [ofw_pkg::SAMPLE_W-1:0] sat;

    assign coef_s = $signed({1'b0, coef});

    // Both operands are sign-extended to the full product width first.
    assign raw_ext  = ofw_pkg::PROD_W'(raw);
    assign coef_ext = ofw_pkg::PROD_W'(coef_s);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= raw_ext * coef_ext;
            raw_reg  <= raw;
        end
    end

    // Arithmetic shift gives the floor of the biased product.
    assign rounded = prod_reg + ofw_pkg::PROD_W'(ofw_pkg::ROUND_BIAS);
    assign quot    = rounded[ofw_pkg::PROD_W-1:ofw_pkg::FRAC_BITS];

    assign overflow = (quot[HI_W-1:ofw_pkg::SAMPLE_W-1]
                       != {(HI_W - ofw_pkg::SAMPLE_W + 1){quot[ofw_pkg::SAMPLE_W-1]}});

    always_comb begin
        if (overflow) begin
            sat = quot[HI_W-1] ? $signed({1'b1, {(ofw_pkg::SAMPLE_W-1){1'b0}}})
                               : $signed({1'b0, {(ofw_pkg::SAMPLE_W-1){1'b1}}});
        end else begin
            sat = quot[ofw_pkg::SAMPLE_W-1:0];
        end
    end

    assign value = window_on ? sat : raw_reg;

endmodule

`default_nettype wire

### hw/rtl/overlapped_frame_windower.sv
`timescale 1ns / 1ps
`default_nettype none

// Overlapped frame windower.
// A sample item that does not finish a frame, and any coefficient item, leaves the input ready
// for the next item. A sample that finishes a frame of L samples is followed by L result items,
// each through ring read, shared multiply and output load, which an output stall holds; no input
// item is taken until the last result of the frame has been loaded into the output register.
// Reset (aresetn low, synchronous) sets frame_len 64, hop 0, window off and clears framing.
module overlapped_frame_windower (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,

    input  wire logic                                     s_valid,
    output logic                                          s_ready,
    input  wire logic                                     s_req_type,
    input  wire logic                                     s_first,
    input  wire logic signed [ofw_pkg::SAMPLE_W-1:0]      s_sample,
    input  wire logic [ofw_pkg::WIN_AW-1:0]               s_coef_index,
    input  wire logic [ofw_pkg::COEF_W-1:0]               s_coef_value,

    output logic                                          m_valid,
    input  wire logic                                     m_ready,
    output logic signed [ofw_pkg::SAMPLE_W-1:0]           m_value,
    output logic [ofw_pkg::FRAME_NUM_W-1:0]               m_frame_number,
    output logic [ofw_pkg::POS_W-1:0]                     m_position,
    output logic                                          m_last,

    input  wire logic                                     cfg_valid,
    output logic                                          cfg_ready,
    input  wire logic [ofw_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  wire logic [ofw_pkg::CFG_DATA_W-1:0]           cfg_data
);

    // The sequencer walks one frame, one sample at a time, through the shared
    // windowing unit. Only one input item is in flight at a time.
    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_MUL, ST_EMIT} state_t;

    state_t                              state_reg, state_next;
    logic [ofw_pkg::REG_W-1:0]           frame_len_reg, frame_len_next;
    logic [ofw_pkg::REG_W-1:0]           hop_reg, hop_next;
    logic                                window_on_reg, window_on_next;
    logic [ofw_pkg::RING_AW-1:0]         wp_reg, wp_next;
    logic [ofw_pkg::REG_W-1:0]           cnt_reg, cnt_next;
    logic [ofw_pkg::FRAME_NUM_W-1:0]     fc_reg, fc_next;
    logic [ofw_pkg::RING_AW-1:0]         k_reg, k_next;
    logic [ofw_pkg::RING_AW-1:0]         start_reg, start_next;
    logic [ofw_pkg::LEN_W-1:0]           len_act_reg, len_act_next;
    logic [ofw_pkg::FRAME_NUM_W-1:0]     frame_num_reg, frame_num_next;
    logic                                m_valid_reg, m_valid_next;
    logic signed [ofw_pkg::SAMPLE_W-1:0] m_value_reg, m_value_next;
    logic [ofw_pkg::FRAME_NUM_W-1:0]     m_frame_number_reg, m_frame_number_next;
    logic [ofw_pkg::POS_W-1:0]           m_position_reg, m_position_next;
    logic                                m_last_reg, m_last_next;

    // Sample ring and window table; neither is cleared, and the block does not check
    // that an entry has been written before it is read.
    logic [ofw_pkg::SAMPLE_W-1:0]        ring_mem [ofw_pkg::FRAME_MAX];
    logic [ofw_pkg::COEF_W-1:0]          win_mem  [ofw_pkg::WIN_DEPTH];
    logic [ofw_pkg::SAMPLE_W-1:0]        ring_rd_reg;
    logic [ofw_pkg::COEF_W-1:0]          win_rd_reg;

    logic                                s_accept;
    logic                                sample_acc;
    logic                                coef_acc;
    logic                                cfg_acc;
    logic [ofw_pkg::RING_AW-1:0]         wp_eff;
    logic [ofw_pkg::REG_W-1:0]           cnt_eff;
    logic [ofw_pkg::FRAME_NUM_W-1:0]     fc_eff;
    logic [ofw_pkg::LEN_W-1:0]           len_now;
    logic [ofw_pkg::RING_AW-1:0]         ring_raddr;
    logic                                out_load;
    logic                                k_last;
    logic                                mac_en;
    logic signed [ofw_pkg::SAMPLE_W-1:0] mac_value;

    assign s_ready    = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign s_accept   = s_valid && s_ready;
    assign sample_acc = s_accept && (s_req_type == ofw_pkg::REQ_SAMPLE);
    assign coef_acc   = s_accept && (s_req_type == ofw_pkg::REQ_COEF);
    assign cfg_acc    = cfg_valid && cfg_ready;

    // A first flag restarts the write pointer, countdown and frame count
    // before the sample itself is stored.
    assign len_now = ofw_pkg::eff_len(frame_len_reg);
    assign wp_eff  = s_first ? '0 : wp_reg;
    assign cnt_eff = s_first ? ofw_pkg::REG_W'(len_now) : cnt_reg;
    assign fc_eff  = s_first ? '0 : fc_reg;

    assign ring_raddr = start_reg + k_reg;
    assign k_last     = ({1'b0, k_reg} == (len_act_reg - ofw_pkg::LEN_W'(1)));
    assign out_load   = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign mac_en     = (state_reg == ST_MUL);

    always_ff @(posedge aclk) begin
        if (sample_acc) begin
            ring_mem[wp_eff] <= s_sample;
        end
        ring_rd_reg <= ring_mem[ring_raddr];
    end

    always_ff @(posedge aclk) begin
        if (coef_acc) begin
            win_mem[s_coef_index] <= s_coef_value;
        end
        win_rd_reg <= win_mem[k_reg];
    end

    ofw_mac u_mac (
        .aclk      (aclk),
        .en        (mac_en),
        .window_on (window_on_reg),
        .raw       ($signed(ring_rd_reg)),
        .coef      (win_rd_reg),
        .value     (mac_value)
    );

    always_comb begin
        state_next          = state_reg;
        frame_len_next      = frame_len_reg;
        hop_next            = hop_reg;
        window_on_next      = window_on_reg;
        wp_next             = wp_reg;
        cnt_next            = cnt_reg;
        fc_next             = fc_reg;
        k_next              = k_reg;
        start_next          = start_reg;
        len_act_next        = len_act_reg;
        frame_num_next      = frame_num_reg;
        m_valid_next        = m_valid_reg;
        m_value_next        = m_value_reg;
        m_frame_number_next = m_frame_number_reg;
        m_position_next     = m_position_reg;
        m_last_next         = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (sample_acc) begin
                    wp_next = wp_eff + ofw_pkg::RING_AW'(1);
                    fc_next = fc_eff;
                    if (cnt_eff > ofw_pkg::REG_W'(1)) begin
                        cnt_next = cnt_eff - ofw_pkg::REG_W'(1);
                    end else begin
                        // This sample closes a frame: the frame starts len
                        // entries behind the updated write pointer.
                        len_act_next   = len_now;
                        start_next     = wp_eff + ofw_pkg::RING_AW'(1)
                                         - len_now[ofw_pkg::RING_AW-1:0];
                        k_next         = '0;
                        frame_num_next = fc_eff;
                        fc_next        = fc_eff + ofw_pkg::FRAME_NUM_W'(1);
                        cnt_next       = ofw_pkg::eff_hop(hop_reg, frame_len_reg);
                        state_next     = ST_READ;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_load) begin
                    if (k_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_reg + ofw_pkg::RING_AW'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Output register: loaded from the windowing unit, emptied when taken.
        if (out_load) begin
            m_valid_next        = 1'b1;
            m_value_next        = mac_value;
            m_frame_number_next = frame_num_reg;
            m_position_next     = ofw_pkg::POS_W'(k_reg);
            m_last_next         = k_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        // Register writes; a new frame length or hop restarts framing.
        if (cfg_acc) begin
            unique case (cfg_index)
                ofw_pkg::CFG_FRAME_LEN: begin
                    frame_len_next = ofw_pkg::REG_W'(cfg_data);
                    wp_next        = '0;
                    fc_next        = '0;
                    cnt_next       = ofw_pkg::REG_W'(ofw_pkg::eff_len(ofw_pkg::REG_W'(cfg_data)));
                end
                ofw_pkg::CFG_HOP: begin
                    hop_next = ofw_pkg::REG_W'(cfg_data);
                    wp_next  = '0;
                    fc_next  = '0;
                    cnt_next = ofw_pkg::REG_W'(len_now);
                end
                ofw_pkg::CFG_WINDOW_ON: begin
                    window_on_next = cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            frame_len_reg <= ofw_pkg::REG_W'(ofw_pkg::FRAME_MAX);
            hop_reg       <= '0;
            window_on_reg <= 1'b0;
            wp_reg        <= '0;
            cnt_reg       <= ofw_pkg::REG_W'(ofw_pkg::FRAME_MAX);
            fc_reg        <= '0;
            k_reg         <= '0;
            len_act_reg   <= ofw_pkg::LEN_W'(1);
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            frame_len_reg <= frame_len_next;
            hop_reg       <= hop_next;
            window_on_reg <= window_on_next;
            wp_reg        <= wp_next;
            cnt_reg       <= cnt_next;
            fc_reg        <= fc_next;
            k_reg         <= k_next;
            len_act_reg   <= len_act_next;
            m_valid_reg   <= m_valid_next;
        end
        start_reg          <= start_next;
        frame_num_reg      <= frame_num_next;
        m_value_reg        <= m_value_next;
        m_frame_number_reg <= m_frame_number_next;
        m_position_reg     <= m_position_next;
        m_last_reg         <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_value        = m_value_reg;
    assign m_frame_number = m_frame_number_reg;
    assign m_position     = m_position_reg;
    assign m_last         = m_last_reg;

    // The position counter never runs past the end of the frame being emitted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> ({1'b0, k_reg} < len_act_reg))
        else $error("position counter beyond frame length");

    // Loading the final result of a frame frees the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && k_last) |=> s_ready)
        else $error("input not ready after final result of frame");

    // A frame walk only ever starts from an accepted audio sample.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg != ST_IDLE) |-> $past(sample_acc))
        else $error("frame walk started without an audio sample");

endmodule

`default_nettype wire
